// ===== hdl/iqddc_pkg.sv =====
// Shared types, widths and constants of the I/Q downconverter and AM/FM demodulator.
// No dependencies; used by iqddc_cordic, iqddc_divider and the top level.
`default_nettype none
package iqddc_pkg;

   localparam int XW   = 18;   // Q15 sample, rotated sample or block mean
   localparam int CW   = 30;   // CORDIC x/y datapath with 8 guard bits
   localparam int ZW   = 34;   // CORDIC angle accumulator
   localparam int KW   = 5;    // index into the arctangent table
   localparam int SUMW = 48;   // box filter sums
   localparam int CNTW = 16;   // block count and decimation factor
   localparam int AW   = 16;   // angle, turns * 2^16
   localparam int LW   = 28;   // demodulated level before clamping
   localparam int PW   = 40;   // |angle step| * FM gain
   localparam int MW   = 39;   // partial products against 2*pi
   localparam int SW   = 33;   // clamped level times audio scale

   localparam logic [29:0] INV_GAIN   = 30'h26DD3B6A;
   localparam int          GAIN_SHIFT = 38;
   localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
   localparam logic signed [15:0] AUDIO_SCALE = 16'sd28000;

   localparam logic [1:0] CSR_PHASE_STEP   = 2'd0;
   localparam logic [1:0] CSR_DECIM_FACTOR = 2'd1;
   localparam logic [1:0] CSR_DEMOD_MODE   = 2'd2;
   localparam logic [1:0] CSR_FM_GAIN      = 2'd3;

   typedef struct packed {
      logic start;
      logic vector;   // 1: vectoring (magnitude and angle), 0: rotation
   } cordic_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

   function automatic logic [31:0] atan_turns(input logic [KW-1:0] k);
      logic [31:0] r;
      unique case (k)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2E;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/iqddc_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on iqddc_pkg. The gain is removed by one shared multiplier, x first, then y.
`default_nettype none
module iqddc_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire iqddc_pkg::cordic_cmd_type      cmd,
   input  wire logic signed [iqddc_pkg::XW-1:0] x0,
   input  wire logic signed [iqddc_pkg::XW-1:0] y0,
   input  wire logic [31:0]                    angle,
   output iqddc_pkg::cordic_sts_type           sts,
   output logic signed [iqddc_pkg::XW-1:0]     ox,
   output logic signed [iqddc_pkg::XW-1:0]     oy,
   output logic [iqddc_pkg::AW-1:0]            ang
);
   import iqddc_pkg::*;

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_ITER = 3'd1;
   localparam logic [2:0] C_MULX = 3'd2;
   localparam logic [2:0] C_MULY = 3'd3;
   localparam logic [2:0] C_LAST = 3'd4;
   localparam logic [KW-1:0] K_LAST = KW'(CORDIC_STEPS - 1);

   logic [2:0]             state_ff;
   logic signed [CW-1:0]   x_ff, y_ff;
   logic signed [ZW-1:0]   z_ff;
   logic [KW-1:0]          k_ff;
   logic                   vec_ff, neg_ff, done_ff;
   logic [CW+29:0]         prod_ff;
   logic signed [XW-1:0]   ox_ff, oy_ff;

   logic signed [CW-1:0]   xs, ys, xsh, ysh, mag_src;
   logic                   flip, sigma;
   logic signed [ZW-1:0]   z_init, at;
   logic [CW-1:0]          mag_u;
   logic [XW-1:0]          scaled;

   always_comb begin
      xs = {{(CW-XW-8){x0[XW-1]}}, x0, 8'b0};
      ys = {{(CW-XW-8){y0[XW-1]}}, y0, 8'b0};
      // Rotation folds angles beyond a quarter turn by a half turn;
      // vectoring folds the left half plane onto the right.
      flip = cmd.vector ? xs[CW-1] : (angle[31] ^ angle[30]);
      if (cmd.vector) begin
         z_init = flip ? ZW'(33'h080000000) : '0;
      end else begin
         z_init = ZW'(signed'({angle[31] ^ flip, angle[30:0]}));
      end
      xsh   = x_ff >>> k_ff;
      ysh   = y_ff >>> k_ff;
      at    = ZW'(atan_turns(k_ff));
      sigma = vec_ff ? y_ff[CW-1] : !z_ff[ZW-1];
      mag_src = (state_ff == C_MULX) ? x_ff : y_ff;
      mag_u   = mag_src[CW-1] ? CW'(-mag_src) : CW'(mag_src);
      scaled  = prod_ff[GAIN_SHIFT +: XW];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         unique case (state_ff)
            C_IDLE: begin
               if (cmd.start) begin
                  x_ff     <= flip ? -xs : xs;
                  y_ff     <= flip ? -ys : ys;
                  z_ff     <= z_init;
                  vec_ff   <= cmd.vector;
                  k_ff     <= '0;
                  state_ff <= C_ITER;
               end
            end
            C_ITER: begin
               if (sigma) begin
                  x_ff <= x_ff - ysh;
                  y_ff <= y_ff + xsh;
                  z_ff <= z_ff - at;
               end else begin
                  x_ff <= x_ff + ysh;
                  y_ff <= y_ff - xsh;
                  z_ff <= z_ff + at;
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == K_LAST) state_ff <= C_MULX;
            end
            C_MULX: begin
               prod_ff  <= mag_u * INV_GAIN;
               neg_ff   <= x_ff[CW-1];
               state_ff <= C_MULY;
            end
            C_MULY: begin
               ox_ff    <= neg_ff ? -signed'(scaled) : signed'(scaled);
               prod_ff  <= mag_u * INV_GAIN;
               neg_ff   <= y_ff[CW-1];
               state_ff <= C_LAST;
            end
            C_LAST: begin
               oy_ff    <= neg_ff ? -signed'(scaled) : signed'(scaled);
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign sts = '{busy: (state_ff != C_IDLE), done: done_ff};
   assign ox  = ox_ff;
   assign oy  = oy_ff;
   assign ang = z_ff[31:16];

endmodule
`default_nettype wire

// ===== hdl/iqddc_divider.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on iqddc_pkg. Divides a block sum by the number of samples in it.
`default_nettype none
module iqddc_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [iqddc_pkg::SUMW-1:0] dividend,
   input  wire logic [iqddc_pkg::CNTW-1:0]        divisor,
   output logic                                   done,
   output logic signed [iqddc_pkg::XW-1:0]        quotient
);
   import iqddc_pkg::*;

   localparam int NW = $clog2(SUMW);
   localparam logic [NW-1:0] N_LAST = NW'(SUMW - 1);

   logic                  busy_ff, neg_ff, done_ff;
   logic [NW-1:0]         cnt_ff;
   logic [SUMW-1:0]       dvd_ff;
   logic [CNTW-1:0]       rem_ff, dsr_ff;
   logic signed [XW-1:0]  q_ff;

   logic [CNTW:0]         trial;
   logic                  ge;
   logic [SUMW-1:0]       dvd_in;
   logic [XW-1:0]         q_low;

   always_comb begin
      trial  = {rem_ff, dvd_ff[SUMW-1]} - {1'b0, dsr_ff};
      ge     = !trial[CNTW];
      dvd_in = {dvd_ff[SUMW-2:0], ge};
      q_low  = dvd_in[XW-1:0];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (!busy_ff) begin
         if (start) begin
            busy_ff <= 1'b1;
            neg_ff  <= dividend[SUMW-1];
            dvd_ff  <= dividend[SUMW-1] ? SUMW'(-dividend) : SUMW'(dividend);
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
      end else begin
         rem_ff <= ge ? trial[CNTW-1:0] : {rem_ff[CNTW-2:0], dvd_ff[SUMW-1]};
         dvd_ff <= dvd_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == N_LAST) begin
            q_ff    <= neg_ff ? -signed'(q_low) : signed'(q_low);
            done_ff <= 1'b1;
            busy_ff <= 1'b0;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

// ===== hdl/iq_downconvert_am_fm_demodulator.sv =====
// I/Q downconverter with box-filter decimation and AM/FM demodulation; needs iqddc_pkg,
// iqddc_cordic and iqddc_divider.
// An item that does not close a block is mixed by the CORDIC and added to the block sums;
// one that closes a block then has its two means divided out in turn, vectored by the
// CORDIC and demodulated, and may wait on a result stall. One item at a time, since the
// CORDIC is iterative and the divider bit-serial. Reset (synchronous) clears phase,
// sums, count and FM history and loads the register defaults.
`default_nettype none
module iq_downconvert_am_fm_demodulator #(
   parameter int PHASE_BITS   = 32,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration port
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   // input items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_sample_i,
   input  wire logic signed [15:0] req_sample_q,
   input  wire logic               req_restart,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_audio
);
   import iqddc_pkg::*;

   // Sequencer codes.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ROT   = 4'd1;
   localparam logic [3:0] ST_ACC   = 4'd2;
   localparam logic [3:0] ST_CHECK = 4'd3;
   localparam logic [3:0] ST_DIVI  = 4'd4;
   localparam logic [3:0] ST_DIVQ  = 4'd5;
   localparam logic [3:0] ST_VEC   = 4'd6;
   localparam logic [3:0] ST_DEMOD = 4'd7;
   localparam logic [3:0] ST_FM2   = 4'd8;
   localparam logic [3:0] ST_FM3   = 4'd9;
   localparam logic [3:0] ST_FMSUM = 4'd10;
   localparam logic [3:0] ST_SCALE = 4'd11;
   localparam logic [3:0] ST_ROUND = 4'd12;

   localparam logic signed [LW-1:0] LVL_MAX = LW'(32768);
   localparam logic signed [LW-1:0] LVL_MIN = -LW'(32768);

   // Configuration registers.
   logic [31:0]     phase_step_ff;
   logic [CNTW-1:0] decim_ff;
   logic            mode_ff;
   logic [23:0]     gain_ff;

   // Item state.
   logic [PHASE_BITS-1:0]  nco_ff;
   logic signed [SUMW-1:0] sum_i_ff, sum_q_ff;
   logic [CNTW-1:0]        count_ff;
   logic [AW-1:0]          last_ang_ff;

   logic [3:0]             state_ff, state_in;
   logic signed [XW-1:0]   rot_i_ff, rot_q_ff, mi_ff, mag_ff;
   logic [AW-1:0]          ang_ff;
   logic [PW-1:0]          p1_ff;
   logic [MW-1:0]          p2_ff, p3_ff;
   logic                   fneg_ff;
   logic signed [LW-1:0]   level_ff;
   logic signed [SW-1:0]   prod_ff;
   logic                   rsp_valid_ff;
   logic signed [15:0]     rsp_audio_ff;

   logic                   req_accept, emit, out_free;
   logic [PHASE_BITS-1:0]  phase_base;
   logic [31:0]            rot_angle;
   logic [CNTW-1:0]        dec_eff;
   logic [AW-1:0]          diff, dmag;
   logic [MW+20:0]         fm_total;
   logic signed [16:0]     clamped;
   logic signed [SW-1:0]   rounded;

   cordic_cmd_type         cordic_cmd;
   cordic_sts_type         cordic_sts;
   logic signed [XW-1:0]   cordic_x0, cordic_y0, cordic_ox, cordic_oy;
   logic [AW-1:0]          cordic_ang;

   logic                   div_start, div_done;
   logic signed [SUMW-1:0] div_dividend;
   logic signed [XW-1:0]   div_q;

   // The block takes an item only with the sequencer at rest.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // A restart clears the NCO before this sample is mixed. The mixer angle is minus
      // the phase, widened to a 32-bit turn value.
      phase_base = req_restart ? '0 : nco_ff;
      rot_angle  = 32'd0 - (32'(phase_base) << (32 - PHASE_BITS));
      // A decimation factor of zero acts as one.
      dec_eff    = (decim_ff == '0) ? CNTW'(1) : decim_ff;
      emit       = (count_ff != '0) && (count_ff >= dec_eff);
      // FM: angle step wrapped to a half turn either way.
      diff       = ang_ff - last_ang_ff;
      dmag       = diff[AW-1] ? (AW'(0) - diff) : diff;
      fm_total   = {p2_ff, 20'b0} + (MW+21)'(p3_ff);
      // Clamp to plus or minus one in Q15.
      if (level_ff > LVL_MAX) begin
         clamped = 17'(LVL_MAX);
      end else if (level_ff < LVL_MIN) begin
         clamped = 17'(LVL_MIN);
      end else begin
         clamped = level_ff[16:0];
      end
      // Divide by 2^15, truncating toward zero.
      rounded    = prod_ff[SW-1] ? ((prod_ff + SW'(32767)) >>> 15) : (prod_ff >>> 15);
   end

   // The CORDIC mixes each input sample, then finds the envelope and angle of each mean.
   always_comb begin
      cordic_cmd.start  = (state_ff == ST_IDLE && req_accept) ||
                          (state_ff == ST_DIVQ && div_done);
      cordic_cmd.vector = (state_ff == ST_DIVQ);
      cordic_x0 = (state_ff == ST_IDLE) ? XW'(req_sample_i) : mi_ff;
      cordic_y0 = (state_ff == ST_IDLE) ? XW'(req_sample_q) : div_q;
   end

   // One divider serves the in-phase mean and then the quadrature mean.
   always_comb begin
      div_start    = (state_ff == ST_CHECK && emit) || (state_ff == ST_DIVI && div_done);
      div_dividend = (state_ff == ST_CHECK) ? sum_i_ff : sum_q_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_ROT;
         ST_ROT:   if (cordic_sts.done) state_in = ST_ACC;
         ST_ACC:   state_in = ST_CHECK;
         ST_CHECK: state_in = emit ? ST_DIVI : ST_IDLE;
         ST_DIVI:  if (div_done) state_in = ST_DIVQ;
         ST_DIVQ:  if (div_done) state_in = ST_VEC;
         ST_VEC:   if (cordic_sts.done) state_in = ST_DEMOD;
         ST_DEMOD: state_in = mode_ff ? ST_SCALE : ST_FM2;
         ST_FM2:   state_in = ST_FM3;
         ST_FM3:   state_in = ST_FMSUM;
         ST_FMSUM: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ROUND;
         ST_ROUND: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         decim_ff      <= CNTW'(1);
         mode_ff       <= 1'b0;
         gain_ff       <= 24'd65536;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PHASE_STEP:   phase_step_ff <= csr_data;
            CSR_DECIM_FACTOR: decim_ff      <= csr_data[CNTW-1:0];
            CSR_DEMOD_MODE:   mode_ff       <= csr_data[0];
            CSR_FM_GAIN:      gain_ff       <= csr_data[23:0];
            default:          ;
         endcase
      end
   end

   // Sequencer and datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nco_ff       <= '0;
         sum_i_ff     <= '0;
         sum_q_ff     <= '0;
         count_ff     <= '0;
         last_ang_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // A new result takes the output register as the old one leaves it.
         if (state_ff == ST_ROUND && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  nco_ff <= phase_base + phase_step_ff[31 -: PHASE_BITS];
                  if (req_restart) begin
                     sum_i_ff    <= '0;
                     sum_q_ff    <= '0;
                     count_ff    <= '0;
                     last_ang_ff <= '0;
                  end
               end
            end
            ST_ROT: begin
               if (cordic_sts.done) begin
                  rot_i_ff <= cordic_ox;
                  rot_q_ff <= cordic_oy;
               end
            end
            ST_ACC: begin
               sum_i_ff <= sum_i_ff + SUMW'(rot_i_ff);
               sum_q_ff <= sum_q_ff + SUMW'(rot_q_ff);
               count_ff <= count_ff + 1'b1;
            end
            ST_CHECK: ;
            ST_DIVI: begin
               if (div_done) mi_ff <= div_q;
            end
            ST_DIVQ: begin
               // Both means are taken: the next block starts empty.
               if (div_done) begin
                  sum_i_ff <= '0;
                  sum_q_ff <= '0;
                  count_ff <= '0;
               end
            end
            ST_VEC: begin
               if (cordic_sts.done) begin
                  mag_ff <= cordic_ox;
                  ang_ff <= cordic_ang;
               end
            end
            ST_DEMOD: begin
               if (mode_ff) begin
                  // AM: twice the envelope minus one.
                  level_ff <= LW'(mag_ff) * LW'(2) - LW'(32768);
               end else begin
                  p1_ff       <= PW'(dmag) * PW'(gain_ff);
                  fneg_ff     <= diff[AW-1];
                  last_ang_ff <= ang_ff;
               end
            end
            ST_FM2: p2_ff <= MW'(p1_ff[PW-1:20] * TWO_PI_Q16);
            ST_FM3: p3_ff <= MW'(p1_ff[19:0] * TWO_PI_Q16);
            ST_FMSUM: begin
               level_ff <= fneg_ff ? -LW'(fm_total[MW+20:33]) : LW'(fm_total[MW+20:33]);
            end
            ST_SCALE: prod_ff <= SW'(clamped) * SW'(AUDIO_SCALE);
            ST_ROUND: begin
               if (out_free) begin
                  rsp_audio_ff <= rounded[15:0];
               end
            end
            default: ;
         endcase
      end
   end

   iqddc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cordic_cmd),
      .x0    (cordic_x0),
      .y0    (cordic_y0),
      .angle (rot_angle),
      .sts   (cordic_sts),
      .ox    (cordic_ox),
      .oy    (cordic_oy),
      .ang   (cordic_ang)
   );

   iqddc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_audio = rsp_audio_ff;

   // The CORDIC works only while the sequencer waits for it.
   a_cordic_owned: assert property (@(posedge clock) disable iff (reset)
      cordic_sts.busy |-> (state_ff == ST_ROT || state_ff == ST_VEC))
      else $error("CORDIC busy outside its sequencer states");

   // Divider results arrive only while a mean is awaited.
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVI || state_ff == ST_DIVQ))
      else $error("divider result with no mean pending");

   // An accepted item always starts the mixer.
   a_accept_rot: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_ROT && cordic_sts.busy))
      else $error("accepted item did not start the CORDIC");

   // A result appears only at the end of a demodulated block.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_ROUND)
      else $error("result item raised outside the output step");

endmodule
`default_nettype wire
